/* rtl/swt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swt_pkg: shared definitions for the shell word tokenizer
// Character codes, result and status codes, and the result record type.
// ----------------------------------------------------------------------------
package swt_pkg;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  localparam logic [7:0] MAX_TOKENS_RESET = 8'd32;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_TOKEN_END = 2'd1,
    KIND_DONE      = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_MANY = 2'd1,
    ST_INVALID  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    QM_NONE   = 2'd0,
    QM_SINGLE = 2'd1,
    QM_DOUBLE = 2'd2
  } quote_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] count;
    status_t    status;
    logic       last;
  } result_t;

endpackage

/* rtl/swt_char_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swt_char_if: input byte channel
// Carries one byte of the command line or an end of line mark per beat.
// ----------------------------------------------------------------------------
interface swt_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_line;

  modport source (output valid, output char_byte, output end_of_line, input ready);
  modport sink (input valid, input char_byte, input end_of_line, output ready);
endinterface

/* rtl/swt_result_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swt_result_if: result channel
// Carries one data byte, token end or line done record per beat.
// ----------------------------------------------------------------------------
interface swt_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] out_byte;
  logic [7:0] word_count;
  logic [1:0] status;
  logic       last_of_run;

  modport source (output valid, output result_kind, output out_byte, output word_count,
                  output status, output last_of_run, input ready);
  modport sink (input valid, input result_kind, input out_byte, input word_count,
                input status, input last_of_run, output ready);
endinterface

/* rtl/shell_word_tokenizer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_word_tokenizer_unit: streaming command line tokenizer
// Splits a byte stream into words with quote and backslash handling.
// ----------------------------------------------------------------------------
// Usage: bytes of a command line enter on the chars channel, one per beat; a
// beat with end_of_line set closes the line. Each kept byte leaves on the
// results channel as a data beat, each word end as a token end beat, and the
// line close as a done beat with the word count and status (possibly preceded
// by a token end beat). last_of_run marks the final beat caused by one input.
// The user must write max_tokens through cfg_wr_en and cfg_wr_data only
// while idle; the block does not enforce this. An accepted input beat is
// held in the input register, then the tokenizer step writes its results
// into the four entry result queue, from which they are offered.
// Throughput: one input beat per cycle while the result queue has room; the
// tokenizer step fires when the input register is full and the queue has
// room for two results; a line close that yields two results writes both.
// Reset: synchronous, clears line state and the queue and sets max_tokens to
// 32. When the receiver stalls, the queue fills and the chars channel drops
// ready; no beat is lost.
// ----------------------------------------------------------------------------
module shell_word_tokenizer_unit
  import swt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [7:0]   cfg_wr_data,
  swt_char_if.sink     chars,
  swt_result_if.source results
);

  logic [7:0] max_tokens;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eol;

  logic       inside_word, inside_word_next;
  quote_t     quote_mode, quote_mode_next;
  logic       escape_pending, escape_pending_next;
  logic [7:0] words_seen, words_seen_next;
  status_t    error_latched, error_latched_next;

  result_t    res0, res1;
  logic [1:0] n_push;
  logic       step;
  logic       is_ws;
  logic       active;
  status_t    eol_stat;

  result_t              fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   head, tail;
  logic [FIFO_AW:0]     count;
  logic                 pop;

  assign step         = in_valid && (count <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
  assign chars.ready  = !in_valid || step;
  assign pop          = results.valid && results.ready;

  assign results.valid       = (count != '0);
  assign results.result_kind = fifo[head].kind;
  assign results.out_byte    = fifo[head].data;
  assign results.word_count  = fifo[head].count;
  assign results.status      = fifo[head].status;
  assign results.last_of_run = fifo[head].last;

  always_comb begin
    inside_word_next    = inside_word;
    quote_mode_next     = quote_mode;
    escape_pending_next = escape_pending;
    words_seen_next     = words_seen;
    error_latched_next  = error_latched;
    res0     = '0;
    res1     = '0;
    n_push   = 2'd0;
    active   = 1'b0;
    eol_stat = error_latched;
    is_ws    = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
    if (in_eol) begin
      if (eol_stat == ST_OK && (escape_pending || quote_mode != QM_NONE)) begin
        eol_stat = ST_INVALID;
      end
      if (eol_stat == ST_OK && inside_word) begin
        res0.kind = KIND_TOKEN_END;
        res1.kind   = KIND_DONE;
        res1.count  = words_seen;
        res1.status = eol_stat;
        res1.last   = 1'b1;
        n_push = 2'd2;
      end else begin
        res0.kind   = KIND_DONE;
        res0.count  = words_seen;
        res0.status = eol_stat;
        res0.last   = 1'b1;
        n_push = 2'd1;
      end
      inside_word_next    = 1'b0;
      quote_mode_next     = QM_NONE;
      escape_pending_next = 1'b0;
      words_seen_next     = '0;
      error_latched_next  = ST_OK;
    end else if (error_latched == ST_OK) begin
      active = 1'b1;
      if (!inside_word) begin
        if (is_ws) begin
          active = 1'b0;
        end else if (words_seen == max_tokens) begin
          error_latched_next = ST_TOO_MANY;
          active = 1'b0;
        end else begin
          words_seen_next  = words_seen + 8'd1;
          inside_word_next = 1'b1;
        end
      end
      if (active) begin
        res0.last = 1'b1;
        res0.data = in_byte;
        res0.kind = KIND_DATA;
        if (escape_pending) begin
          escape_pending_next = 1'b0;
          n_push = 2'd1;
        end else if (in_byte == CH_BSLASH && quote_mode != QM_SINGLE) begin
          escape_pending_next = 1'b1;
        end else if (quote_mode != QM_NONE) begin
          if ((quote_mode == QM_SINGLE && in_byte == CH_SQUOTE) ||
              (quote_mode == QM_DOUBLE && in_byte == CH_DQUOTE)) begin
            quote_mode_next = QM_NONE;
          end else begin
            n_push = 2'd1;
          end
        end else if (in_byte == CH_SQUOTE) begin
          quote_mode_next = QM_SINGLE;
        end else if (in_byte == CH_DQUOTE) begin
          quote_mode_next = QM_DOUBLE;
        end else if (is_ws) begin
          inside_word_next = 1'b0;
          res0.kind = KIND_TOKEN_END;
          res0.data = '0;
          n_push = 2'd1;
        end else begin
          n_push = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_tokens     <= MAX_TOKENS_RESET;
      in_valid       <= 1'b0;
      inside_word    <= 1'b0;
      quote_mode     <= QM_NONE;
      escape_pending <= 1'b0;
      words_seen     <= '0;
      error_latched  <= ST_OK;
      head           <= '0;
      tail           <= '0;
      count          <= '0;
    end else begin
      if (cfg_wr_en) begin
        max_tokens <= cfg_wr_data;
      end
      if (chars.valid && chars.ready) begin
        in_valid <= 1'b1;
      end else if (step) begin
        in_valid <= 1'b0;
      end
      if (step) begin
        inside_word    <= inside_word_next;
        quote_mode     <= quote_mode_next;
        escape_pending <= escape_pending_next;
        words_seen     <= words_seen_next;
        error_latched  <= error_latched_next;
        tail           <= tail + FIFO_AW'(n_push);
      end
      if (pop) begin
        head <= head + FIFO_AW'(1);
      end
      count <= count + (step ? (FIFO_AW+1)'(n_push) : '0) - (FIFO_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      in_byte <= chars.char_byte;
      in_eol  <= chars.end_of_line;
    end
    if (step && n_push != 2'd0) begin
      fifo[tail] <= res0;
    end
    if (step && n_push == 2'd2) begin
      fifo[tail + FIFO_AW'(1)] <= res1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    step && in_eol |=> words_seen == '0 && quote_mode == QM_NONE && !escape_pending)
    else $error("line state not cleared after end of line");

  a_error_silent: assert property (@(posedge clk) disable iff (rst)
    step && !in_eol && error_latched != ST_OK |-> n_push == 2'd0)
    else $error("results emitted after latched error");

  a_words_bound: assert property (@(posedge clk) disable iff (rst)
    step && !in_eol && words_seen == max_tokens |-> words_seen_next == words_seen)
    else $error("word count passed the limit");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the shell word tokenizer
// Drives command lines of well-formed, broken and noisy words into the chars
// channel under random sender and receiver idling, predicts every result beat
// in a scoreboard and compares each received beat field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import swt_pkg::*;

  class token_scoreboard;
    logic [7:0] limit;
    logic       in_word;
    quote_t     qmode;
    logic       esc;
    logic [7:0] words;
    status_t    err;
    result_t    expected_q[$];
    int         mismatches;
    int         checked;
    int         lines;
    int         too_many_lines;
    int         invalid_lines;

    function new();
      limit = MAX_TOKENS_RESET;
      clear_line();
    endfunction

    function void clear_line();
      in_word = 1'b0;
      qmode = QM_NONE;
      esc = 1'b0;
      words = 8'd0;
      err = ST_OK;
    endfunction

    function void set_limit(logic [7:0] v);
      limit = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function result_t make(kind_t k, logic [7:0] d, logic [7:0] n, status_t s);
      result_t r;
      r.kind = k;
      r.data = d;
      r.count = n;
      r.status = s;
      r.last = 1'b0;
      return r;
    endfunction

    function void note_input(logic [7:0] c, logic eol);
      result_t outq[$];
      status_t st;
      logic    ws;
      logic    go;
      if (eol) begin
        st = err;
        if (st == ST_OK && (esc || qmode != QM_NONE)) st = ST_INVALID;
        if (st == ST_OK && in_word) outq.push_back(make(KIND_TOKEN_END, 8'd0, 8'd0, ST_OK));
        outq.push_back(make(KIND_DONE, 8'd0, words, st));
        lines++;
        if (st == ST_TOO_MANY) too_many_lines++;
        if (st == ST_INVALID) invalid_lines++;
        clear_line();
      end else if (err == ST_OK) begin
        ws = (c == CH_SPACE) || (c == CH_TAB);
        go = 1'b1;
        if (!in_word) begin
          if (ws) begin
            go = 1'b0;
          end else if (words == limit) begin
            err = ST_TOO_MANY;
            go = 1'b0;
          end else begin
            words++;
            in_word = 1'b1;
          end
        end
        if (go) begin
          if (esc) begin
            esc = 1'b0;
            outq.push_back(make(KIND_DATA, c, 8'd0, ST_OK));
          end else if (c == CH_BSLASH && qmode != QM_SINGLE) begin
            esc = 1'b1;
          end else if (qmode != QM_NONE) begin
            if (c == ((qmode == QM_SINGLE) ? CH_SQUOTE : CH_DQUOTE)) qmode = QM_NONE;
            else outq.push_back(make(KIND_DATA, c, 8'd0, ST_OK));
          end else if (c == CH_SQUOTE) begin
            qmode = QM_SINGLE;
          end else if (c == CH_DQUOTE) begin
            qmode = QM_DOUBLE;
          end else if (ws) begin
            in_word = 1'b0;
            outq.push_back(make(KIND_TOKEN_END, 8'd0, 8'd0, ST_OK));
          end else begin
            outq.push_back(make(KIND_DATA, c, 8'd0, ST_OK));
          end
        end
      end
      if (outq.size() > 0) outq[outq.size() - 1].last = 1'b1;
      foreach (outq[i]) expected_q.push_back(outq[i]);
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("Unexpected result beat: kind %0d byte %0h", got.kind, got.data);
        mismatches++;
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (got.kind !== exp_r.kind) begin
        $error("result_kind: expected %0d, got %0d", exp_r.kind, got.kind);
        mismatches++;
      end
      if (got.data !== exp_r.data) begin
        $error("out_byte: expected %0h, got %0h", exp_r.data, got.data);
        mismatches++;
      end
      if (got.count !== exp_r.count) begin
        $error("word_count: expected %0d, got %0d", exp_r.count, got.count);
        mismatches++;
      end
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, got.status);
        mismatches++;
      end
      if (got.last !== exp_r.last) begin
        $error("last_of_run: expected %0d, got %0d", exp_r.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  swt_char_if   chars_if();
  swt_result_if res_if();

  shell_word_tokenizer_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .chars       (chars_if),
    .results     (res_if)
  );

  token_scoreboard sb = new();
  int         send_idle = 0;
  int         recv_idle = 0;
  int         beats_sent = 0;
  bit         hold_go = 1'b0;
  int         hold_cnt = 0;
  logic [7:0] line_bytes[$];
  result_t    seen_result;

  always #10 clk = ~clk;

  initial begin
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 8'd0;
    chars_if.valid <= 1'b0;
    chars_if.char_byte <= 8'd0;
    chars_if.end_of_line <= 1'b0;
    res_if.ready <= 1'b0;
  end

  // The receiver holds ready low for a long stretch when asked, else it idles at random.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        hold_cnt = 80;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && chars_if.valid && chars_if.ready) begin
      sb.note_input(chars_if.char_byte, chars_if.end_of_line);
    end
    if (!rst && res_if.valid && res_if.ready) begin
      seen_result.kind = kind_t'(res_if.result_kind);
      seen_result.data = res_if.out_byte;
      seen_result.count = res_if.word_count;
      seen_result.status = status_t'(res_if.status);
      seen_result.last = res_if.last_of_run;
      sb.check_result(seen_result);
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic e);
    while ($urandom_range(0, 99) < send_idle) begin
      chars_if.valid <= 1'b0;
      @(posedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.char_byte <= b;
    chars_if.end_of_line <= e;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_line();
    foreach (line_bytes[i]) send_beat(line_bytes[i], 1'b0);
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic wait_drained();
    chars_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_limit(v);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CH_SPACE || b == CH_TAB || b == CH_BSLASH || b == CH_SQUOTE || b == CH_DQUOTE)
      b = b ^ 8'h40;
    return b;
  endfunction

  function automatic void push_sep();
    repeat ($urandom_range(1, 2)) line_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endfunction

  function automatic void push_piece();
    logic [7:0] b;
    case ($urandom_range(0, 4))
      0: repeat ($urandom_range(1, 4)) line_bytes.push_back(plain_byte());
      1: begin
        line_bytes.push_back(CH_SQUOTE);
        repeat ($urandom_range(0, 3)) begin
          b = 8'($urandom_range(0, 255));
          line_bytes.push_back((b == CH_SQUOTE) ? CH_BSLASH : b);
        end
        line_bytes.push_back(CH_SQUOTE);
      end
      2: begin
        line_bytes.push_back(CH_DQUOTE);
        repeat ($urandom_range(0, 3)) begin
          b = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 2) == 0 || b == CH_BSLASH || b == CH_DQUOTE) begin
            line_bytes.push_back(CH_BSLASH);
          end
          line_bytes.push_back(b);
        end
        line_bytes.push_back(CH_DQUOTE);
      end
      3: begin
        line_bytes.push_back(CH_BSLASH);
        line_bytes.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        b = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        line_bytes.push_back(b);
        line_bytes.push_back(b);
      end
    endcase
  endfunction

  function automatic void gen_line();
    int pick;
    line_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 3) == 0) push_sep();
    for (int w = 0; w < $urandom_range(0, 6); w++) begin
      if (w > 0) push_sep();
      repeat ($urandom_range(1, 3)) push_piece();
    end
    if ($urandom_range(0, 3) == 0) push_sep();
    if (pick < 16) begin
      case ($urandom_range(0, 2))
        0: line_bytes.push_back(CH_BSLASH);
        1: begin
          line_bytes.push_back(CH_SQUOTE);
          line_bytes.push_back(plain_byte());
        end
        default: line_bytes.push_back(CH_DQUOTE);
      endcase
    end
  endfunction

  int         seg_send[6] = '{26, 26, 68, 68, 0, 0};
  int         seg_recv[6] = '{68, 68, 26, 26, 0, 0};
  logic [7:0] seg_limit[6] = '{8'd0, 8'd5, 8'd255, 8'd3, 8'd1, 8'd2};
  int         seg_start;

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle = 10;
    recv_idle = 10;
    write_limit(8'd2);

    // Zero and all-ones bytes inside a word, tab as separator.
    line_bytes = '{8'h00, 8'hFF, CH_TAB, 8'h62};
    send_line();
    // Single quotes keep backslash and double quote; escaped quote inside double quotes.
    line_bytes = '{CH_SQUOTE, CH_BSLASH, CH_DQUOTE, CH_SQUOTE, CH_SPACE,
                   CH_DQUOTE, CH_BSLASH, CH_DQUOTE, CH_DQUOTE};
    send_line();
    // Escaped space forms a word; the third word exceeds the limit of two.
    line_bytes = '{CH_BSLASH, CH_SPACE, CH_SPACE, 8'h62, CH_SPACE, 8'h63};
    send_line();
    // Unclosed double quote, then a dangling backslash, then an empty line.
    line_bytes = '{CH_DQUOTE, 8'h71};
    send_line();
    line_bytes = '{8'h78, CH_BSLASH};
    send_line();
    line_bytes.delete();
    send_line();

    for (int s = 0; s < 6; s++) begin
      wait_drained();
      if (s == 5) seg_limit[s] = 8'($urandom_range(0, 8));
      write_limit(seg_limit[s]);
      send_idle = seg_send[s];
      recv_idle = seg_recv[s];
      seg_start = beats_sent;
      if (s == 4) begin
        hold_go = 1'b1;
        line_bytes.delete();
        repeat (6) begin
          repeat (4) line_bytes.push_back(plain_byte());
          line_bytes.push_back(CH_SPACE);
        end
        send_line();
      end
      while (beats_sent - seg_start < 120) begin
        gen_line();
        send_line();
        if (s >= 4 && $urandom_range(0, 7) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (6) @(posedge clk);
    $display("Sent %0d beats in %0d lines and checked %0d result beats.",
             beats_sent, sb.lines, sb.checked);
    $display("%0d lines hit the word limit and %0d lines ended malformed.",
             sb.too_many_lines, sb.invalid_lines);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
